FILE: rtl/okls_pkg.sv
// ----------------------------------------------------------------------------
// okls_pkg
// Shared types and constants of the ordered keyed list store.
// ----------------------------------------------------------------------------
package okls_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int TYPE_BITS_DEF = 4;

	localparam int KEY_W     = 16;
	localparam int KTYPE_W   = 4;
	localparam int PAY_W     = 32;
	localparam int OPCODE_W  = 3;
	localparam int STATUS_W  = 2;
	localparam int POS_W     = 4;
	localparam int COUNT_W   = 5;

	typedef enum logic [OPCODE_W-1:0] {
		OP_APPEND   = 3'd0,
		OP_REM_HEAD = 3'd1,
		OP_REM_KEY  = 3'd2,
		OP_FIND     = 3'd3,
		OP_CLEAR    = 3'd4
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_HEAD,
		S_SCAN,
		S_SHIFT,
		S_RESULT
	} state_t;

	typedef struct packed {
		status_t              status;
		logic [PAY_W-1:0]     payload;
		logic [POS_W-1:0]     position;
		logic [COUNT_W-1:0]   count;
	} res_t;

endpackage

FILE: rtl/ordered_keyed_list_store_core.sv
// ----------------------------------------------------------------------------
// Append, clear and unused codes go from the execute state straight to the
// result state; remove head passes through the head state; find and keyed
// removal scan the entries from the head, and keyed removal then moves the
// later entries forward to close the gap. One item is in work at a time: a new
// item is taken only when idle, after the result is handed on. Reset clears
// count and head; the entry memory is not cleared.
// ----------------------------------------------------------------------------
// ordered_keyed_list_store_core
// Bounded ordered keyed store on a circular buffer, with a stream interface.
// ----------------------------------------------------------------------------
module ordered_keyed_list_store_core #(
	parameter int DEPTH     = okls_pkg::DEPTH_DEF,
	parameter int TYPE_BITS = okls_pkg::TYPE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // key_id[15:0], key_type[19:16], payload_in[51:20]
	input  logic [2:0]  s_tuser,  // opcode[2:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,  // payload_out[31:0], position[35:32], entry_count[40:36]
	output logic [1:0]  m_tuser   // status[1:0]
);

	import okls_pkg::*;

	logic  res_valid, res_ready;
	res_t  res;
	logic  out_valid_q;
	res_t  out_q;

	okls_ctrl #(
		.DEPTH     (DEPTH),
		.TYPE_BITS (TYPE_BITS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser),
		.in_key    (s_tdata[15:0]),
		.in_type   (s_tdata[19:16]),
		.in_pay    (s_tdata[51:20]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {7'd0, out_q.count, out_q.position, out_q.payload};

endmodule

FILE: rtl/okls_ram.sv
// ----------------------------------------------------------------------------
// okls_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module okls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/okls_ctrl.sv
// ----------------------------------------------------------------------------
// okls_ctrl
// Sequencer of the store: keeps head and count of the circular buffer and
// runs append, removal, scan and gap closing against the entry memory.
// ----------------------------------------------------------------------------
module okls_ctrl #(
	parameter int DEPTH     = okls_pkg::DEPTH_DEF,
	parameter int TYPE_BITS = okls_pkg::TYPE_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [okls_pkg::OPCODE_W-1:0]      in_op,
	input  logic [okls_pkg::KEY_W-1:0]         in_key,
	input  logic [okls_pkg::KTYPE_W-1:0]       in_type,
	input  logic [okls_pkg::PAY_W-1:0]         in_pay,
	output logic                               res_valid,
	input  logic                               res_ready,
	output okls_pkg::res_t                     res
);

	import okls_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int WW = KEY_W + TYPE_BITS + PAY_W;
	localparam logic [AW:0]   DEPTH_W = (AW + 1)'(DEPTH);
	localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

	state_t               state_q, state_d;
	logic [AW-1:0]        head_q, head_d;
	logic [CW-1:0]        cnt_q, cnt_d;
	logic [AW-1:0]        idx_q, idx_d;
	status_t              st_q, st_d;
	logic [PAY_W-1:0]     pout_q, pout_d;
	logic [AW-1:0]        pos_q, pos_d;

	op_t                  op_q;
	logic [KEY_W-1:0]     key_q;
	logic [TYPE_BITS-1:0] type_q;
	logic [PAY_W-1:0]     pay_q;

	logic                 we;
	logic [AW-1:0]        waddr, raddr;
	logic [WW-1:0]        wdata, rdata;

	logic [KEY_W-1:0]     rd_key;
	logic [TYPE_BITS-1:0] rd_type;
	logic [PAY_W-1:0]     rd_pay;
	logic                 hit;
	logic [AW-1:0]        last_idx, nxt_idx, nxt2_idx;

	function automatic logic [AW-1:0] phys(input logic [AW-1:0] base, input logic [AW-1:0] off);
		logic [AW:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= DEPTH_W) begin
			sum = sum - DEPTH_W;
		end
		return sum[AW-1:0];
	endfunction

	okls_ram #(
		.WIDTH(WW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_key   = rdata[KEY_W-1:0];
	assign rd_type  = rdata[KEY_W +: TYPE_BITS];
	assign rd_pay   = rdata[KEY_W + TYPE_BITS +: PAY_W];
	assign hit      = (rd_key == key_q) && (rd_type == type_q);
	assign last_idx = AW'(cnt_q - CW'(1));
	assign nxt_idx  = idx_q + AW'(1);
	assign nxt2_idx = nxt_idx + AW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q  <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		st_q   <= st_d;
		pout_q <= pout_d;
		pos_q  <= pos_d;
		if (in_valid && in_ready) begin
			op_q   <= op_t'(in_op);
			key_q  <= in_key;
			type_q <= TYPE_BITS'(in_type);
			pay_q  <= in_pay;
		end
	end

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		cnt_d     = cnt_q;
		idx_d     = idx_q;
		st_d      = st_q;
		pout_d    = pout_q;
		pos_d     = pos_q;
		we        = 1'b0;
		waddr     = head_q;
		wdata     = rdata;
		raddr     = head_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				st_d    = ST_DONE;
				pout_d  = '0;
				pos_d   = '0;
				idx_d   = '0;
				state_d = S_RESULT;
				unique case (op_q)
					OP_APPEND: begin
						if (cnt_q == FULL_C) begin
							st_d = ST_FULL;
						end else begin
							we    = 1'b1;
							waddr = phys(head_q, AW'(cnt_q));
							wdata = {pay_q, type_q, key_q};
							cnt_d = cnt_q + CW'(1);
						end
					end
					OP_REM_HEAD: begin
						if (cnt_q == '0) begin
							st_d = ST_EMPTY;
						end else begin
							state_d = S_HEAD;
						end
					end
					OP_REM_KEY, OP_FIND: begin
						if (cnt_q == '0) begin
							st_d = ST_EMPTY;
						end else begin
							state_d = S_SCAN;
						end
					end
					OP_CLEAR: begin
						cnt_d = '0;
					end
					default: begin
					end
				endcase
			end
			S_HEAD: begin
				pout_d  = rd_pay;
				head_d  = phys(head_q, AW'(1));
				cnt_d   = cnt_q - CW'(1);
				state_d = S_RESULT;
			end
			S_SCAN: begin
				if (hit) begin
					pout_d = rd_pay;
					pos_d  = idx_q;
					if (op_q == OP_FIND) begin
						state_d = S_RESULT;
					end else if (idx_q == '0) begin
						head_d  = phys(head_q, AW'(1));
						cnt_d   = cnt_q - CW'(1);
						state_d = S_RESULT;
					end else if (idx_q == last_idx) begin
						cnt_d   = cnt_q - CW'(1);
						state_d = S_RESULT;
					end else begin
						raddr   = phys(head_q, nxt_idx);
						state_d = S_SHIFT;
					end
				end else if (idx_q == last_idx) begin
					st_d    = ST_EMPTY;
					state_d = S_RESULT;
				end else begin
					idx_d = nxt_idx;
					raddr = phys(head_q, nxt_idx);
				end
			end
			S_SHIFT: begin
				we    = 1'b1;
				waddr = phys(head_q, idx_q);
				wdata = rdata;
				if (nxt_idx == last_idx) begin
					cnt_d   = cnt_q - CW'(1);
					state_d = S_RESULT;
				end else begin
					idx_d = nxt_idx;
					raddr = phys(head_q, nxt2_idx);
				end
			end
			S_RESULT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign res.status   = st_q;
	assign res.payload  = pout_q;
	assign res.position = POS_W'(pos_q);
	assign res.count    = COUNT_W'(cnt_q);

endmodule

FILE: rtl/okls_checker.sv
// ----------------------------------------------------------------------------
// okls_checker
// Port-level checks of the ordered keyed list store.
// ----------------------------------------------------------------------------
module okls_checker #(
	parameter int DEPTH = okls_pkg::DEPTH_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [55:0] s_tdata,
	input logic [2:0]  s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic [1:0]  m_tuser
);

	import okls_pkg::*;

	logic [COUNT_W-1:0] cnt;
	logic               any_in;

	assign cnt    = m_tdata[40:36];
	assign any_in = s_tvalid || (|s_tdata) || (|s_tuser);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("Result item changed while stalled.");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_FULL |-> cnt == COUNT_W'(DEPTH))
		else $error("Full status with a store that is not full.");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_EMPTY |-> m_tdata[35:0] == 36'd0)
		else $error("Miss result carries payload or position.");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (DEPTH >= 32 || cnt <= COUNT_W'(DEPTH)) && m_tuser != 2'd3)
		else $error("Result count or status out of range.");

	a_no_busy_take: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && any_in |=> !s_tready)
		else $error("Second item taken while one is in work.");

endmodule

bind ordered_keyed_list_store_core okls_checker #(.DEPTH(DEPTH)) u_okls_checker (.*);
